>>> sv/skt_pkg.sv
// Shared types and constants for the sorted key table lookup block.
// No dependencies; imported by skt_ctrl, skt_dp, sorted_key_table_lookup and its testbench.
package skt_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 160;

	// item modes
	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// result status codes
	localparam logic [2:0] ST_HIT   = 3'd0;
	localparam logic [2:0] ST_MISS  = 3'd1;
	localparam logic [2:0] ST_DONE  = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_ORDER = 3'd4;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t        key;
		logic [63:0] offset;
		logic [31:0] length;
	} rec_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic probe;
		logic compare;
		logic emit_miss;
	} skt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_lookup;
		logic range_empty;
		logic key_eq;
	} skt_stat_t;

endpackage

>>> sv/sorted_key_table_lookup.sv
// Top level of the sorted key table: binary search over loaded 160-bit keys.
// Depends on skt_pkg, skt_ctrl and skt_dp.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  command  | start / busy     | mode, key_high, key_mid, key_low, rec_offset,
//           |                  | rec_length
//  result   | done (1 cycle)   | status, found_offset, found_length
//
// A word is taken when start is high and busy low. Clear, load and unused modes
// finish in the execute state; a lookup then repeats a probe (memory read, then key
// compare) until a hit, or emits a miss once the search range is empty. The
// registered read of the record memory sets the probe loop pace. Reset empties
// the table; the memory needs no clearing.
// The result strobe cannot be stalled.
module sorted_key_table_lookup
	import skt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [63:0] key_high,
	input  logic [63:0] key_mid,
	input  logic [31:0] key_low,
	input  logic [63:0] rec_offset,
	input  logic [31:0] rec_length,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] found_offset,
	output logic [31:0] found_length
);

	skt_cmd_t  cmd;
	skt_stat_t stat;

	skt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	skt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode),
		.key_high     (key_high),
		.key_mid      (key_mid),
		.key_low      (key_low),
		.rec_offset   (rec_offset),
		.rec_length   (rec_length),
		.cmd          (cmd),
		.stat         (stat),
		.done         (done),
		.status       (status),
		.found_offset (found_offset),
		.found_length (found_length)
	);

endmodule

>>> sv/skt_ctrl.sv
// Sequencer for the sorted key table: capture, execute, probe/compare loop.
// Depends on skt_pkg.
module skt_ctrl
	import skt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  skt_stat_t stat,
	output skt_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;
	localparam logic [1:0] S_CMP   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = stat.is_lookup ? S_PROBE : S_IDLE;
			end
			S_PROBE: begin
				if (stat.range_empty) begin
					cmd.emit_miss = 1'b1;
					state_nxt     = S_IDLE;
				end else begin
					cmd.probe = 1'b1;
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				// datapath narrows the range or reports the hit itself
				cmd.compare = 1'b1;
				state_nxt   = stat.key_eq ? S_IDLE : S_PROBE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> sv/skt_dp.sv
// Datapath: record memory, entry count, search bounds and result registers.
// Depends on skt_pkg; driven by skt_ctrl commands.
module skt_dp
	import skt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  mode,
	input  logic [63:0] key_high,
	input  logic [63:0] key_mid,
	input  logic [31:0] key_low,
	input  logic [63:0] rec_offset,
	input  logic [31:0] rec_length,
	input  skt_cmd_t    cmd,
	output skt_stat_t   stat,
	output logic        done,
	output logic [2:0]  status,
	output logic [63:0] found_offset,
	output logic [31:0] found_length
);

	rec_t mem [TABLE_DEPTH];

	logic [1:0]       mode_q;
	rec_t             in_q;
	key_t             last_key_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] mid_q;
	rec_t             rd_q;
	logic             done_q;
	logic [2:0]       status_q;
	logic [63:0]      off_q;
	logic [31:0]      len_q;

	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] mid;
	logic             is_full;
	logic             out_of_order;
	logic             load_ok;
	logic             rd_less;
	logic             rd_eq;

	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[CNT_W:1];

	assign is_full      = (count_q >= CNT_W'(TABLE_DEPTH));
	assign out_of_order = (count_q != '0) && (last_key_q > in_q.key);
	assign load_ok      = cmd.exec && (mode_q == MODE_LOAD) && !is_full && !out_of_order;

	assign rd_less = (rd_q.key < in_q.key);
	assign rd_eq   = (rd_q.key == in_q.key);

	assign stat.is_lookup   = (mode_q == MODE_LOOKUP);
	assign stat.range_empty = (lo_q >= hi_q);
	assign stat.key_eq      = rd_eq;

	// record memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[count_q[ADDR_W-1:0]] <= in_q;
		end
		if (cmd.probe) begin
			rd_q <= mem[mid[ADDR_W-1:0]];
		end
	end

	// captured word and search bounds
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q.key    <= {key_high, key_mid, key_low};
			in_q.offset <= rec_offset;
			in_q.length <= rec_length;
		end
		if (load_ok) begin
			last_key_q <= in_q.key;
		end
		if (cmd.exec) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.probe) begin
			mid_q <= mid;
		end else if (cmd.compare && !rd_eq) begin
			if (rd_less) begin
				lo_q <= mid_q + CNT_W'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_CLEAR;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				mode_q <= mode;
			end
			if (cmd.exec && (mode_q == MODE_CLEAR)) begin
				count_q <= '0;
			end else if (load_ok) begin
				count_q <= count_q + CNT_W'(1);
			end
			done_q <= (cmd.exec && (mode_q != MODE_LOOKUP)) || cmd.emit_miss ||
				(cmd.compare && rd_eq);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		off_q <= '0;
		len_q <= '0;
		if (cmd.exec) begin
			case (mode_q)
				MODE_CLEAR: status_q <= ST_DONE;
				MODE_LOAD: begin
					if (is_full) begin
						status_q <= ST_FULL;
					end else if (out_of_order) begin
						status_q <= ST_ORDER;
					end else begin
						status_q <= ST_DONE;
					end
				end
				default: status_q <= ST_MISS;
			endcase
		end else if (cmd.emit_miss) begin
			status_q <= ST_MISS;
		end else if (cmd.compare && rd_eq) begin
			status_q <= ST_HIT;
			off_q    <= rd_q.offset;
			len_q    <= rd_q.length;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found_offset = off_q;
	assign found_length = len_q;

endmodule

>>> verif/sorted_key_table_lookup_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_table_lookup: directed and random command words
// checked against a shadow table with its own binary search. Depends on skt_pkg and the RTL.
module sorted_key_table_lookup_tb;
	import skt_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 550;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT  = 1000;
	localparam key_t KEY_MAX    = '1;

	typedef struct packed {
		logic [1:0]  mode;
		key_t        key;
		logic [63:0] offset;
		logic [31:0] length;
	} cmd_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] offset;
		logic [31:0] length;
	} lookup_result_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  mode       = MODE_CLEAR;
	logic [63:0] key_high   = '0;
	logic [63:0] key_mid    = '0;
	logic [31:0] key_low    = '0;
	logic [63:0] rec_offset = '0;
	logic [31:0] rec_length = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [63:0] found_offset;
	logic [31:0] found_length;

	// shadow copy of the record table
	key_t        tbl_key [TABLE_DEPTH];
	logic [63:0] tbl_off [TABLE_DEPTH];
	logic [31:0] tbl_len [TABLE_DEPTH];
	int          tbl_count = 0;

	lookup_result_t pending_results [$];
	int error_count  = 0;
	int words_sent   = 0;
	int stall_cycles = 0;
	bit no_gap       = 1'b0;

	sorted_key_table_lookup u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.key_high     (key_high),
		.key_mid      (key_mid),
		.key_low      (key_low),
		.rec_offset   (rec_offset),
		.rec_length   (rec_length),
		.done         (done),
		.status       (status),
		.found_offset (found_offset),
		.found_length (found_length)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic key_t rand_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// Applies one word to the shadow table and returns the result it must produce.
	function automatic lookup_result_t table_response(cmd_word_t w);
		lookup_result_t r;
		int lo;
		int hi;
		int mid;
		bit found;
		r.status = ST_MISS;
		r.offset = '0;
		r.length = '0;
		case (w.mode)
		MODE_CLEAR: begin
			tbl_count = 0;
			r.status = ST_DONE;
		end
		MODE_LOAD: begin
			if (tbl_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else if (tbl_count > 0 && tbl_key[tbl_count-1] > w.key) begin
				r.status = ST_ORDER;
			end else begin
				tbl_key[tbl_count] = w.key;
				tbl_off[tbl_count] = w.offset;
				tbl_len[tbl_count] = w.length;
				tbl_count++;
				r.status = ST_DONE;
			end
		end
		MODE_LOOKUP: begin
			lo = 0;
			hi = tbl_count;
			found = 1'b0;
			// floor midpoint; first equal probe wins among duplicates
			while (lo < hi && !found) begin
				mid = (lo + hi) / 2;
				if (tbl_key[mid] < w.key) begin
					lo = mid + 1;
				end else if (tbl_key[mid] > w.key) begin
					hi = mid;
				end else begin
					found = 1'b1;
					r.status = ST_HIT;
					r.offset = tbl_off[mid];
					r.length = tbl_len[mid];
				end
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// Next key that keeps the table in order: equal, +1 or a step of random size.
	function automatic key_t ordered_key();
		key_t base;
		key_t step;
		key_t k;
		if (tbl_count == 0) begin
			if ($urandom_range(0, 3) == 0)
				return rand_key();
			return rand_key() >> $urandom_range(1, 159);
		end
		base = tbl_key[tbl_count-1];
		case ($urandom_range(0, 5))
		0: step = '0;
		1: step = key_t'(1);
		2: step = rand_key() >> $urandom_range(1, 159);
		3: step = key_t'($urandom);
		4: step = key_t'(rand64()) << 32;
		default: step = rand_key() >> $urandom_range(100, 159);
		endcase
		k = base + step;
		return (k < base) ? base : k;
	endfunction

	// Half the time a loaded key as it is, else a neighbor of one or a random key.
	function automatic key_t probe_key();
		key_t k;
		if (tbl_count == 0)
			k = rand_key();
		else
			k = tbl_key[$urandom_range(0, tbl_count - 1)];
		case ($urandom_range(0, 9))
		0, 1: k = k + 1;
		2: k = k - 1;
		3, 4: k = rand_key();
		default: ;
		endcase
		return k;
	endfunction

	task automatic issue_word(input logic [1:0] m, input key_t k, input logic [63:0] off,
		input logic [31:0] len);
		cmd_word_t w;
		int gap;
		w = '{m, k, off, len};
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode       <= m;
		key_high   <= k[159:96];
		key_mid    <= k[95:32];
		key_low    <= k[31:0];
		rec_offset <= off;
		rec_length <= len;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(table_response(w));
		words_sent++;
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_table();
		no_gap = 1'b0;
		issue_word(MODE_LOOKUP, '0, '0, '0);
		issue_word(MODE_LOOKUP, KEY_MAX, '1, '1);
		issue_word(MODE_UNUSED, KEY_MAX, '1, '1);
		issue_word(MODE_CLEAR, '0, '0, '0);
	endtask

	task automatic test_directed_loads();
		key_t mid_key;
		mid_key = (rand_key() >> 1) | key_t'(2);
		issue_word(MODE_LOAD, '0, '1, '1);
		issue_word(MODE_LOAD, '0, 64'h0123_4567_89ab_cdef, 32'h5a5a_a5a5);
		issue_word(MODE_LOAD, mid_key, rand64(), $urandom);
		issue_word(MODE_LOAD, mid_key - 1, rand64(), $urandom);
		issue_word(MODE_LOAD, mid_key, rand64(), $urandom);
		issue_word(MODE_LOAD, KEY_MAX, '0, '0);
		issue_word(MODE_LOAD, mid_key, rand64(), $urandom);
		issue_word(MODE_UNUSED, mid_key, '1, '1);
		issue_word(MODE_LOOKUP, '0, '0, '0);
		issue_word(MODE_LOOKUP, mid_key, '0, '0);
		issue_word(MODE_LOOKUP, KEY_MAX, '0, '0);
		issue_word(MODE_LOOKUP, mid_key - 1, '0, '0);
		issue_word(MODE_LOOKUP, mid_key + 1, '0, '0);
		issue_word(MODE_LOOKUP, KEY_MAX - 1, '0, '0);
		issue_word(MODE_CLEAR, KEY_MAX, '1, '1);
		issue_word(MODE_LOOKUP, mid_key, '0, '0);
		// after a clear any first key is in order
		issue_word(MODE_LOAD, KEY_MAX, rand64(), $urandom);
		issue_word(MODE_LOAD, '0, rand64(), $urandom);
		issue_word(MODE_LOOKUP, KEY_MAX, '0, '0);
		wait_results_drained();
	endtask

	task automatic test_full_table();
		issue_word(MODE_CLEAR, '0, '0, '0);
		issue_word(MODE_LOAD, '0, rand64(), $urandom);
		while (tbl_count < TABLE_DEPTH - 1) begin
			if (tbl_count % 256 == 0)
				no_gap = ($urandom_range(0, 7) != 0);
			issue_word(MODE_LOAD, ordered_key(), rand64(), $urandom);
		end
		issue_word(MODE_LOAD, KEY_MAX, '1, '1);
		no_gap = 1'b0;
		issue_word(MODE_LOAD, KEY_MAX, rand64(), $urandom);
		issue_word(MODE_LOAD, '0, rand64(), $urandom);
		issue_word(MODE_LOOKUP, '0, '0, '0);
		issue_word(MODE_LOOKUP, KEY_MAX, '0, '0);
		repeat (20) issue_word(MODE_LOOKUP, probe_key(), rand64(), $urandom);
		wait_results_drained();
		issue_word(MODE_CLEAR, '0, '0, '0);
		issue_word(MODE_LOOKUP, '0, '0, '0);
	endtask

	// Often a clear, then ordered loads with some bad ones mixed in, then a run of lookups.
	task automatic test_random();
		int goal;
		int n_load;
		int n_look;
		key_t last;
		goal = words_sent + RANDOM_WORDS;
		while (words_sent < goal) begin
			no_gap = ($urandom_range(0, 3) == 0);
			if (tbl_count > 2000 || $urandom_range(0, 2) != 0)
				issue_word(MODE_CLEAR, rand_key(), rand64(), $urandom);
			if ($urandom_range(0, 3) == 0)
				n_load = $urandom_range(0, 60);
			else
				n_load = $urandom_range(0, 12);
			repeat (n_load) begin
				case ($urandom_range(0, 19))
				0: begin
					last = (tbl_count > 0) ? tbl_key[tbl_count-1] : '0;
					if (last != '0)
						issue_word(MODE_LOAD, rand_key() % last, rand64(), $urandom);
					else
						issue_word(MODE_LOAD, rand_key(), rand64(), $urandom);
				end
				1: issue_word(MODE_UNUSED, rand_key(), rand64(), $urandom);
				default: issue_word(MODE_LOAD, ordered_key(), rand64(), $urandom);
				endcase
			end
			n_look = $urandom_range(1, 25);
			repeat (n_look) begin
				if ($urandom_range(0, 9) == 0)
					issue_word(MODE_UNUSED, rand_key(), rand64(), $urandom);
				else
					issue_word(MODE_LOOKUP, probe_key(), rand64(), $urandom);
			end
			if ($urandom_range(0, 7) == 0)
				wait_results_drained();
		end
	endtask

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result word with no command pending, status %0d", status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (found_offset !== want.offset) begin
					$error("found_offset: expected %h, got %h", want.offset, found_offset);
					error_count++;
				end
				if (found_length !== want.length) begin
					$error("found_length: expected %h, got %h", want.length, found_length);
					error_count++;
				end
			end
		end
	end

	// watchdog: no word moved on either side for too long
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no word moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed_loads();
		test_full_table();
		test_random();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
sv/skt_pkg.sv
sv/skt_ctrl.sv
sv/skt_dp.sv
sv/sorted_key_table_lookup.sv
verif/sorted_key_table_lookup_tb.sv
